// ===== rtl/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

  localparam int CP_W     = 21;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = 2;
  localparam int Q_CNT_W  = 3;

  localparam logic [CP_W-1:0] ERR_CP    = 21'h00FFFD;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
  localparam logic [CP_W-1:0] LIM_2B    = 21'h000080;
  localparam logic [CP_W-1:0] LIM_3B    = 21'h000800;
  localparam logic [CP_W-1:0] LIM_4B    = 21'h010000;
  localparam logic [CP_W-1:0] LIM_MAX   = 21'h110000;

  // Sequence lengths as held in the expected-length register
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // One classified byte: error words first, then an optional good word
  typedef struct packed {
    logic [2:0]      n_err;
    logic            good;
    logic [CP_W-1:0] cp;
  } u8d_entry_t;

endpackage : u8d_pkg

`default_nettype wire

// ===== rtl/u8d_front.sv =====
// ----------------------------------------------------------------------------
// u8d_front
// Classifies each byte against the pending sequence and yields at most one entry
// that lists how many error words and whether one good word follow.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_front
  import u8d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_stream,
  output logic            push,
  output u8d_entry_t      push_entry
);

  logic [2:0]      exp_len_r, exp_len_nxt;
  logic [1:0]      seen_r, seen_nxt;
  logic [CP_W-1:0] partial_r, partial_nxt;

  logic            is_cont;
  logic            lead_path;
  logic [2:0]      seen_inc;
  logic [CP_W-1:0] cp_cat;
  logic [2:0]      lead_len;
  logic [2:0]      short_len;
  logic            bad_val;
  u8d_entry_t      ent;

  // Decode the length a lead byte announces
  always_comb begin
    if (data_byte < 8'h80)      lead_len = LEN_1;
    else if (data_byte < 8'hC0) lead_len = LEN_NONE;
    else if (data_byte < 8'hE0) lead_len = LEN_2;
    else if (data_byte < 8'hF0) lead_len = LEN_3;
    else if (data_byte < 8'hF8) lead_len = LEN_4;
    else                        lead_len = LEN_NONE;
  end

  // Append the continuation bits and check the finished value
  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign seen_inc = {1'b0, seen_r} + 3'd1;
  assign cp_cat   = {partial_r[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    if (cp_cat < LIM_2B)       short_len = LEN_1;
    else if (cp_cat < LIM_3B)  short_len = LEN_2;
    else if (cp_cat < LIM_4B)  short_len = LEN_3;
    else if (cp_cat < LIM_MAX) short_len = LEN_4;
    else                       short_len = LEN_NONE;
  end

  assign bad_val = (short_len != exp_len_r) ||
                   ((cp_cat >= SURR_LO) && (cp_cat <= SURR_HI));

  // Classify the byte and compute the next sequence state
  always_comb begin
    ent         = '0;
    exp_len_nxt = exp_len_r;
    seen_nxt    = seen_r;
    partial_nxt = partial_r;
    lead_path   = 1'b1;

    if (exp_len_r != LEN_NONE) begin
      if (is_cont) begin
        lead_path = 1'b0;
        if (seen_inc >= exp_len_r) begin
          if (bad_val) begin
            ent.n_err = exp_len_r;
          end else begin
            ent.good = 1'b1;
            ent.cp   = cp_cat;
          end
          exp_len_nxt = LEN_NONE;
          seen_nxt    = 2'd0;
          partial_nxt = '0;
        end else begin
          seen_nxt    = seen_inc[1:0];
          partial_nxt = cp_cat;
        end
      end else begin
        // Broken sequence: flush what was taken, then retry as a lead
        ent.n_err   = {1'b0, seen_r};
        exp_len_nxt = LEN_NONE;
        seen_nxt    = 2'd0;
        partial_nxt = '0;
      end
    end

    if (lead_path) begin
      case (lead_len)
        LEN_NONE: begin
          ent.n_err = ent.n_err + 3'd1;
        end
        LEN_1: begin
          ent.good = 1'b1;
          ent.cp   = {{(CP_W-8){1'b0}}, data_byte};
        end
        LEN_2: begin
          exp_len_nxt = LEN_2;
          seen_nxt    = 2'd1;
          partial_nxt = {{(CP_W-8){1'b0}}, data_byte & 8'h1F};
        end
        LEN_3: begin
          exp_len_nxt = LEN_3;
          seen_nxt    = 2'd1;
          partial_nxt = {{(CP_W-8){1'b0}}, data_byte & 8'h0F};
        end
        LEN_4: begin
          exp_len_nxt = LEN_4;
          seen_nxt    = 2'd1;
          partial_nxt = {{(CP_W-8){1'b0}}, data_byte & 8'h07};
        end
        default: begin
          ent.n_err = ent.n_err + 3'd1;
        end
      endcase
    end

    // Flush a pending sequence on the final byte
    if (end_of_stream && (exp_len_nxt != LEN_NONE)) begin
      ent.n_err   = ent.n_err + {1'b0, seen_nxt};
      exp_len_nxt = LEN_NONE;
      seen_nxt    = 2'd0;
      partial_nxt = '0;
    end
  end

  assign push       = accept && ((ent.n_err != 3'd0) || ent.good);
  assign push_entry = ent;

  // Advance the sequence state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= LEN_NONE;
      seen_r    <= 2'd0;
      partial_r <= '0;
    end else if (accept) begin
      exp_len_r <= exp_len_nxt;
      seen_r    <= seen_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule : u8d_front

`default_nettype wire

// ===== rtl/u8d_queue.sv =====
// ----------------------------------------------------------------------------
// u8d_queue
// Short FIFO of classified entries between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_queue
  import u8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire u8d_entry_t  push_entry,
  input  wire logic        pop,
  output u8d_entry_t       head,
  output logic             empty,
  output logic             full
);

  u8d_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  // Move pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule : u8d_queue

`default_nettype wire

// ===== rtl/u8d_back.sv =====
// ----------------------------------------------------------------------------
// u8d_back
// Expands each queued entry into its result words, one per cycle while
// out_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_back
  import u8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire u8d_entry_t  head,
  input  wire logic        empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [CP_W-1:0]  out_code_point,
  output logic             out_is_error,
  output logic             out_last_of_run
);

  logic [2:0]      idx_r, idx_nxt;
  logic            valid_r;
  logic [CP_W-1:0] cp_r;
  logic            err_r;
  logic            last_r;

  logic            advance;
  logic            load;
  logic [2:0]      total;
  logic            cur_err;
  logic            cur_last;

  assign advance  = !valid_r || out_ready;
  assign load     = advance && !empty;
  assign total    = head.n_err + {2'b00, head.good};
  assign cur_err  = (idx_r < head.n_err);
  assign cur_last = ((idx_r + 3'd1) == total);
  assign pop      = load && cur_last;
  assign idx_nxt  = cur_last ? 3'd0 : idx_r + 3'd1;

  // Step through the words of the head entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else if (advance) begin
      valid_r <= !empty;
      if (load) begin
        idx_r <= idx_nxt;
      end
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= cur_err ? ERR_CP : head.cp;
      err_r  <= cur_err;
      last_r <= cur_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_code_point  = cp_r;
  assign out_is_error    = err_r;
  assign out_last_of_run = last_r;

endmodule : u8d_back

`default_nettype wire

// ===== rtl/utf8_stream_decoder.sv =====
// The entry queue registers each accepted word that yields results, and the
// registered output stage then raises out_valid for its first result.
// Throughput: one input word per cycle while the queue has a free slot; the
// output stage gives one result per cycle while out_ready is high, and a
// four-entry queue absorbs the burst of a word that yields several results.
// Reset: synchronous, active low; clears the pending sequence, the queue and
// the output valid.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder with validation: front classifier, entry queue
// and result expander.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_end_of_stream,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [CP_W-1:0]      out_code_point,
  output logic                 out_is_error,
  output logic                 out_last_of_run
);

  logic       accept;
  logic       push;
  u8d_entry_t push_entry;
  logic       pop;
  u8d_entry_t head;
  logic       empty;
  logic       full;

  // Accept whenever the queue has a free slot
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  u8d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .end_of_stream (in_end_of_stream),
    .push          (push),
    .push_entry    (push_entry)
  );

  u8d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  u8d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_is_error    (out_is_error),
    .out_last_of_run (out_last_of_run)
  );

endmodule : utf8_stream_decoder

`default_nettype wire

// ===== rtl/u8d_checker.sv =====
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks on the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_checker
  import u8d_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic [CP_W-1:0] out_code_point,
  input wire logic            out_is_error,
  input wire logic            out_last_of_run
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point) &&
    $stable(out_is_error) && $stable(out_last_of_run))
    else $error("result word changed while stalled");

  // Error words carry the replacement character
  a_err_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_error |-> out_code_point == ERR_CP)
    else $error("error word without replacement code point");

  // Good words are scalar values: in range and not surrogates
  a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_error |-> (out_code_point < LIM_MAX) &&
    ((out_code_point < SURR_LO) || (out_code_point > SURR_HI)))
    else $error("good word outside the scalar range");

  // A good word always closes the run of its input byte
  a_good_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_error |-> out_last_of_run)
    else $error("good word not marked last of run");

endmodule : u8d_checker

bind utf8_stream_decoder u8d_checker u_chk (.*);

`default_nettype wire
